// ===== rtl/askc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// askc_pkg
// Types and constants shared by the adaptive sample k-mer counter.
// ----------------------------------------------------------------------------
package askc_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int LEVELS_DEF        = 64;

  localparam int HASH_W   = 64;
  localparam int COUNT_W  = 32;
  localparam int LEVEL_W  = 6;
  localparam int THR_W    = 7;
  localparam int LIMIT_W  = 11;
  localparam int COVER_W  = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 11'd1024;
  localparam logic [COVER_W-1:0] COVER_RST = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COVERAGE = 1'd1;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [63:0] kmer_hash;
    logic [6:0]  freq_index;
  } in_t;

  typedef struct packed {
    logic [6:0]  threshold_level;
    logic [10:0] sample_size;
    logic [63:0] distinct_estimate;
    logic [63:0] kmer_total;
    logic [63:0] freq_estimate;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
    logic [COUNT_W-1:0] count;
    logic [HASH_W-1:0]  hash;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_CHECK,
    ST_DROP,
    ST_COUNT,
    ST_REPORT
  } state_t;

endpackage

// ===== rtl/adaptive_sample_kmer_counter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_sample_kmer_counter_core
// Adaptive distinct sample of k-mer hashes by trailing-zero level, with
// saturating counts, level drops and report beats.
// ----------------------------------------------------------------------------
// channel | signals                          | direction | beat
// in      | in_valid  in_ready  in_data      | input     | add or report item
// out     | out_valid out_ready out_data     | output    | report result
// cfg     | cfg_valid cfg_ready cfg_index/data | input   | register write
//
// Add: an item below threshold is only counted; else the table is scanned to a hit,
// a miss inserts into the first free slot, and each level drop rescans the table.
// Report: a histogram class first scans the table, else no scan is made.
// Reset runs a clearing pass over every table entry with in_ready low.
// A stalled result holds in the output register; the next item is still taken.
// ----------------------------------------------------------------------------
module adaptive_sample_kmer_counter_core #(
  parameter int TABLE_ENTRIES = askc_pkg::TABLE_ENTRIES_DEF,
  parameter int LEVELS        = askc_pkg::LEVELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  askc_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output askc_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [askc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [askc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW   = $clog2(TABLE_ENTRIES);
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int LIMW = (CW > askc_pkg::LIMIT_W) ? CW : askc_pkg::LIMIT_W;
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
  localparam int EW = $bits(askc_pkg::entry_t);

  function automatic logic [askc_pkg::LEVEL_W-1:0] level_of(input logic [63:0] h);
    logic [askc_pkg::LEVEL_W-1:0] z;
    z = askc_pkg::LEVEL_W'(LEVELS - 1);
    for (int i = 63; i >= 0; i--) begin
      if (h[i] && (i < LEVELS - 1)) z = askc_pkg::LEVEL_W'(i);
    end
    return z;
  endfunction

  function automatic logic [63:0] sat_shl(input logic [63:0] v, input logic [6:0] s);
    logic [63:0] r;
    if (v == 64'd0) r = 64'd0;
    else if (s >= 7'd64) r = '1;
    else if ((s != 7'd0) && ((v >> (7'd64 - s)) != 64'd0)) r = '1;
    else r = v << s;
    return r;
  endfunction

  askc_pkg::state_t state, state_next;
  logic [AW-1:0] rd_addr, rd_addr_next, didx, didx_next, slot, slot_next;
  logic rd_done, rd_done_next, dv, dv_next, slot_ok, slot_ok_next;
  logic [63:0] cur_hash, cur_hash_next, seen, seen_next;
  logic [askc_pkg::LEVEL_W-1:0] cur_lvl, cur_lvl_next;
  logic [6:0] fi, fi_next, thr, thr_next;
  logic [CW-1:0] held, held_next, match_cnt, match_cnt_next;
  logic [askc_pkg::LIMIT_W-1:0] limit, limit_next;
  logic [askc_pkg::COVER_W-1:0] maxcov, maxcov_next;
  logic out_valid_next;
  askc_pkg::out_t out_data_next;

  logic wen, ren;
  logic [AW-1:0] waddr;
  askc_pkg::entry_t wentry, rentry;
  logic [EW-1:0] rdata;
  logic [LIMW-1:0] lim;
  logic [askc_pkg::LEVEL_W-1:0] in_lvl;

  askc_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (EW'(wentry)),
    .ren   (ren),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign rentry    = askc_pkg::entry_t'(rdata);
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == askc_pkg::ST_IDLE);
  assign in_lvl    = level_of(in_data.kmer_hash);

  always_comb begin
    lim = LIMW'(limit);
    if (limit == '0) lim = LIMW'(1);
    if (lim > LIMW'(TABLE_ENTRIES)) lim = LIMW'(TABLE_ENTRIES);
  end

  always_comb begin
    state_next     = state;
    rd_addr_next   = rd_addr;
    rd_done_next   = rd_done;
    dv_next        = 1'b0;
    didx_next      = rd_addr;
    slot_next      = slot;
    slot_ok_next   = slot_ok;
    cur_hash_next  = cur_hash;
    cur_lvl_next   = cur_lvl;
    fi_next        = fi;
    thr_next       = thr;
    held_next      = held;
    match_cnt_next = match_cnt;
    seen_next      = seen;
    limit_next     = limit;
    maxcov_next    = maxcov;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    wen            = 1'b0;
    ren            = 1'b0;
    waddr          = didx;
    wentry         = rentry;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        askc_pkg::REG_SAMPLE_LIMIT: limit_next = cfg_data[askc_pkg::LIMIT_W-1:0];
        askc_pkg::REG_MAX_COVERAGE: maxcov_next = cfg_data[askc_pkg::COVER_W-1:0];
        default: ;
      endcase
    end

    if (out_valid && out_ready) out_valid_next = 1'b0;

    if ((state == askc_pkg::ST_SCAN || state == askc_pkg::ST_DROP ||
         state == askc_pkg::ST_COUNT) && !rd_done) begin
      ren          = 1'b1;
      dv_next      = 1'b1;
      rd_addr_next = rd_addr + AW'(1);
      rd_done_next = (rd_addr == LAST);
    end

    case (state)
      askc_pkg::ST_CLEAR: begin
        wen          = 1'b1;
        waddr        = rd_addr;
        wentry       = '0;
        rd_addr_next = rd_addr + AW'(1);
        if (rd_addr == LAST) state_next = askc_pkg::ST_IDLE;
      end
      askc_pkg::ST_IDLE: begin
        rd_addr_next = '0;
        rd_done_next = 1'b0;
        if (in_valid) begin
          if (in_data.mode == askc_pkg::MODE_ADD) begin
            if (seen != '1) seen_next = seen + 64'd1;
            cur_hash_next = in_data.kmer_hash;
            cur_lvl_next  = in_lvl;
            slot_ok_next  = 1'b0;
            if ({1'b0, in_lvl} >= thr) state_next = askc_pkg::ST_SCAN;
          end else begin
            fi_next        = in_data.freq_index;
            match_cnt_next = '0;
            if (in_data.freq_index != 7'd0 && in_data.freq_index <= maxcov) begin
              state_next = askc_pkg::ST_COUNT;
            end else begin
              state_next = askc_pkg::ST_REPORT;
            end
          end
        end
      end
      askc_pkg::ST_SCAN: begin
        if (dv) begin
          if (rentry.valid && rentry.hash == cur_hash) begin
            wen = 1'b1;
            if (rentry.count != '1) wentry.count = rentry.count + 32'd1;
            state_next = askc_pkg::ST_IDLE;
          end else begin
            if (!rentry.valid && !slot_ok) begin
              slot_next    = didx;
              slot_ok_next = 1'b1;
            end
            if (didx == LAST) state_next = askc_pkg::ST_INSERT;
          end
        end
      end
      askc_pkg::ST_INSERT: begin
        if (slot_ok) begin
          wen          = 1'b1;
          waddr        = slot;
          wentry.valid = 1'b1;
          wentry.level = cur_lvl;
          wentry.count = 32'd1;
          wentry.hash  = cur_hash;
          held_next    = held + CW'(1);
          state_next   = askc_pkg::ST_CHECK;
        end else begin
          state_next = askc_pkg::ST_IDLE;
        end
      end
      askc_pkg::ST_CHECK: begin
        rd_addr_next = '0;
        rd_done_next = 1'b0;
        if (LIMW'(held) >= lim && thr < 7'(LEVELS)) begin
          state_next = askc_pkg::ST_DROP;
        end else begin
          state_next = askc_pkg::ST_IDLE;
        end
      end
      askc_pkg::ST_DROP: begin
        if (dv) begin
          if (rentry.valid && rentry.level == thr[askc_pkg::LEVEL_W-1:0]) begin
            wen          = 1'b1;
            wentry.valid = 1'b0;
            if (held != '0) held_next = held - CW'(1);
          end
          if (didx == LAST) begin
            thr_next   = thr + 7'd1;
            state_next = askc_pkg::ST_CHECK;
          end
        end
      end
      askc_pkg::ST_COUNT: begin
        if (dv) begin
          if (rentry.valid && rentry.count == 32'(fi)) match_cnt_next = match_cnt + CW'(1);
          if (didx == LAST) state_next = askc_pkg::ST_REPORT;
        end
      end
      askc_pkg::ST_REPORT: begin
        if (!out_valid || out_ready) begin
          out_valid_next                  = 1'b1;
          out_data_next.threshold_level   = thr;
          out_data_next.sample_size       = 11'(held);
          out_data_next.distinct_estimate = sat_shl(64'(held), thr);
          out_data_next.kmer_total        = seen;
          out_data_next.freq_estimate     = sat_shl(64'(match_cnt), thr);
          state_next                      = askc_pkg::ST_IDLE;
        end
      end
      default: state_next = askc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= askc_pkg::ST_CLEAR;
      rd_addr   <= '0;
      rd_done   <= 1'b0;
      dv        <= 1'b0;
      slot_ok   <= 1'b0;
      held      <= '0;
      thr       <= '0;
      seen      <= '0;
      limit     <= askc_pkg::LIMIT_RST;
      maxcov    <= askc_pkg::COVER_RST;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_addr   <= rd_addr_next;
      rd_done   <= rd_done_next;
      dv        <= dv_next;
      slot_ok   <= slot_ok_next;
      held      <= held_next;
      thr       <= thr_next;
      seen      <= seen_next;
      limit     <= limit_next;
      maxcov    <= maxcov_next;
      out_valid <= out_valid_next;
    end
    didx      <= didx_next;
    slot      <= slot_next;
    cur_hash  <= cur_hash_next;
    cur_lvl   <= cur_lvl_next;
    fi        <= fi_next;
    match_cnt <= match_cnt_next;
    out_data  <= out_data_next;
  end

endmodule

// ===== rtl/askc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// askc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module askc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/askc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// askc_checker
// Port-level checks on the adaptive sample k-mer counter, bound to the core.
// ----------------------------------------------------------------------------
module askc_checker #(
  parameter int TABLE_ENTRIES = askc_pkg::TABLE_ENTRIES_DEF,
  parameter int LEVELS        = askc_pkg::LEVELS_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input askc_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_clear_pass: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during clearing pass");

  a_thr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.threshold_level <= 7'(LEVELS))
    else $error("threshold beyond level range");

  a_freq_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.threshold_level == 7'd0 |->
      out_data.freq_estimate <= 64'(TABLE_ENTRIES))
    else $error("frequency class larger than table");

endmodule

bind adaptive_sample_kmer_counter_core askc_checker #(
  .TABLE_ENTRIES(TABLE_ENTRIES),
  .LEVELS(LEVELS)
) u_askc_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the adaptive sample k-mer counter core. A driver sends add and
// report beats from a pending queue, with register writes between phases.
// A local model of the sampling table predicts each report result, and a
// monitor checks the results field by field under random output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import askc_pkg::*;

  localparam int ENTRIES  = 1024;
  localparam int NLEVELS  = 64;
  localparam int WDOG_MAX = 400000;
  localparam int HOLD_LEN = 30000;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    in_t                   data;
    bit                    burst;
  } pend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adaptive_sample_kmer_counter_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  pend_t pending_q[$];
  out_t  report_q[$];

  // sample table shadow
  logic [63:0] tb_hash[ENTRIES];
  logic [31:0] tb_count[ENTRIES];
  logic [5:0]  tb_level[ENTRIES];
  bit          tb_valid[ENTRIES];
  int unsigned held_cnt;
  int unsigned thr_lvl;
  logic [63:0] seen_cnt;
  logic [10:0] limit_reg;
  logic [6:0]  cover_reg;

  int mismatches = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int wdog = 0;

  function automatic int unsigned hash_level(logic [63:0] h);
    int unsigned z;
    z = 0;
    if (h == 64'd0) return NLEVELS - 1;
    while (z < 63 && h[z] == 1'b0) z++;
    if (z > NLEVELS - 1) z = NLEVELS - 1;
    return z;
  endfunction

  function automatic logic [63:0] sat_shift(logic [63:0] v, int unsigned s);
    if (v == 64'd0) return 64'd0;
    if (s >= 64 || v > ({64{1'b1}} >> s)) return {64{1'b1}};
    return v << s;
  endfunction

  function automatic int unsigned eff_limit();
    int unsigned l;
    l = limit_reg;
    if (l == 0) l = 1;
    if (l > ENTRIES) l = ENTRIES;
    return l;
  endfunction

  task automatic drop_threshold_level();
    for (int i = 0; i < ENTRIES; i++) begin
      if (tb_valid[i] && tb_level[i] == thr_lvl) begin
        tb_valid[i] = 0;
        if (held_cnt > 0) held_cnt--;
      end
    end
    thr_lvl++;
  endtask

  task automatic sample_hash(logic [63:0] h);
    int unsigned lvl;
    int slot;
    lvl = hash_level(h);
    slot = ENTRIES;
    if (seen_cnt != {64{1'b1}}) seen_cnt++;
    if (lvl < thr_lvl) return;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tb_valid[i] && tb_hash[i] == h) begin
        if (tb_count[i] != 32'hFFFF_FFFF) tb_count[i]++;
        return;
      end
      if (!tb_valid[i] && slot == ENTRIES) slot = i;
    end
    if (slot == ENTRIES) return;
    tb_valid[slot] = 1;
    tb_hash[slot]  = h;
    tb_count[slot] = 32'd1;
    tb_level[slot] = lvl[5:0];
    held_cnt++;
    while (held_cnt >= eff_limit() && thr_lvl < NLEVELS) drop_threshold_level();
  endtask

  task automatic predict_beat(in_t it);
    out_t r;
    logic [63:0] hits;
    hits = 0;
    if (it.mode == MODE_ADD) begin
      sample_hash(it.kmer_hash);
    end else begin
      if (it.freq_index != 0 && it.freq_index <= cover_reg) begin
        for (int i = 0; i < ENTRIES; i++)
          if (tb_valid[i] && tb_count[i] == {25'd0, it.freq_index}) hits++;
      end
      r.threshold_level   = thr_lvl[6:0];
      r.sample_size       = held_cnt[10:0];
      r.distinct_estimate = sat_shift(64'(held_cnt), thr_lvl);
      r.kmer_total        = seen_cnt;
      r.freq_estimate     = sat_shift(hits, thr_lvl);
      report_q.push_back(r);
    end
  endtask

  // driver
  int  gap_left = 0;
  bit  cur_burst = 0;
  always @(posedge clk) begin
    bit nv, cv;
    pend_t p;
    nv = in_valid;
    cv = cfg_valid;
    if (rst) begin
      nv = 0;
      cv = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_beat(in_data);
        nv = 0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SAMPLE_LIMIT) limit_reg = cfg_data;
        else cover_reg = cfg_data[6:0];
        cv = 0;
      end
      if (report_q.size() == 0 && !nv && !in_valid) quiet_cycles++;
      else quiet_cycles = 0;
      if (!nv && !cv && pending_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          p = pending_q[0];
          if (p.is_cfg) begin
            if (quiet_cycles >= 16) begin
              cfg_index <= p.idx;
              cfg_data  <= p.val;
              cv = 1;
              void'(pending_q.pop_front());
            end
          end else begin
            in_data <= p.data;
            nv = 1;
            void'(pending_q.pop_front());
            gap_left = p.burst ? 0 : $urandom_range(0, 16);
          end
        end
      end
    end
    in_valid  <= nv;
    cfg_valid <= cv;
  end

  // monitor
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    out_t e;
    bit rdy;
    rdy = out_ready;
    if (rst) begin
      rdy = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          e = report_q.pop_front();
          if (out_data.threshold_level !== e.threshold_level ||
              out_data.sample_size !== e.sample_size ||
              out_data.distinct_estimate !== e.distinct_estimate ||
              out_data.kmer_total !== e.kmer_total ||
              out_data.freq_estimate !== e.freq_estimate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected %p actual %p",
                       results_seen, e, out_data);
          end
        end
        rdy = 0;
        if (!hold_done && results_seen == 40) begin
          hold_done = 1;
          hold_left = HOLD_LEN;
        end
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        rdy = 1;
      end
    end
    out_ready <= rdy;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      wdog <= 0;
    else if (wdog + 1 >= WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end else
      wdog <= wdog + 1;
  end

  task automatic push_add(logic [63:0] h, bit b);
    pend_t p;
    p.is_cfg = 0; p.idx = '0; p.val = '0; p.burst = b;
    p.data.mode = MODE_ADD;
    p.data.kmer_hash = h;
    p.data.freq_index = 7'($urandom);
    pending_q.push_back(p);
  endtask

  task automatic push_report(logic [6:0] f, bit b);
    pend_t p;
    p.is_cfg = 0; p.idx = '0; p.val = '0; p.burst = b;
    p.data.mode = MODE_REPORT;
    p.data.kmer_hash = {$urandom, $urandom};
    p.data.freq_index = f;
    pending_q.push_back(p);
  endtask

  task automatic push_cfg(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] v);
    pend_t p;
    push_report(7'd0, 0);
    p.is_cfg = 1; p.idx = i; p.val = v; p.burst = 0;
    p.data = '0;
    pending_q.push_back(p);
  endtask

  function automatic logic [63:0] rand_hash(ref logic [63:0] pool[8]);
    case ($urandom_range(0, 3))
      0: return pool[$urandom_range(0, 7)];
      1: return {$urandom, $urandom};
      2: return {$urandom, $urandom} << $urandom_range(0, 63);
      default: return $urandom_range(0, 1) ? 64'd0 : (64'd1 << $urandom_range(40, 63));
    endcase
  endfunction

  initial begin
    logic [10:0] lims[8];
    logic [10:0] covs[8];
    logic [63:0] pool[8];
    bit b;
    lims = '{11'd1024, 11'd2047, 11'd300, 11'd64, 11'd5, 11'd2, 11'd0, 11'd1};
    covs = '{11'd64, 11'h7FF, 11'd0, 11'd5, 11'd3, 11'd64, 11'd1, 11'd64};
    for (int i = 0; i < ENTRIES; i++) tb_valid[i] = 0;
    held_cnt = 0; thr_lvl = 0; seen_cnt = 0;
    limit_reg = LIMIT_RST; cover_reg = COVER_RST;

    // directed: extremes, hits, report classes
    push_add(64'd0, 0);
    push_add({64{1'b1}}, 0);
    push_add(64'h8000_0000_0000_0000, 1);
    push_add({64{1'b1}}, 1);
    push_add(64'h0000_0001_0000_0000, 0);
    push_report(7'd0, 0);
    push_report(7'd1, 0);
    push_report(7'd2, 1);
    push_report(7'd64, 0);
    push_report(7'd65, 0);
    push_report(7'd127, 0);
    push_cfg(REG_SAMPLE_LIMIT, 11'd2);
    push_add(64'h4000_0000_0000_0000, 0);
    push_add(64'h2000_0000_0000_0000, 0);
    push_add(64'd6, 0);
    push_report(7'd1, 0);
    push_cfg(REG_SAMPLE_LIMIT, 11'd1024);

    for (int ph = 0; ph < 8; ph++) begin
      push_cfg(REG_SAMPLE_LIMIT, lims[ph]);
      push_cfg(REG_MAX_COVERAGE, covs[ph]);
      for (int k = 0; k < 8; k++) pool[k] = {$urandom, $urandom} << $urandom_range(0, 8);
      b = ph[0];
      for (int n = 0; n < 210; n++) begin
        if ($urandom_range(0, 4) == 0)
          push_report(($urandom_range(0, 3) == 0) ? 7'($urandom) :
                      7'($urandom_range(0, 6)), b);
        else
          push_add(rand_hash(pool), b);
      end
    end
    push_report(7'd1, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() > 0 || in_valid || cfg_valid || report_q.size() > 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && report_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/askc_pkg.sv
rtl/askc_ram.sv
rtl/adaptive_sample_kmer_counter_core.sv
rtl/askc_checker.sv
bench/tb_top.sv
